// ===== design/sample_batch_spi_framer_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sample batch framer
// Shared concurrent assertion helpers, clocked on clk, reset by arst_n.
// ----------------------------------------------------------------------------
`ifndef SAMPLE_BATCH_SPI_FRAMER_MACROS_SVH
`define SAMPLE_BATCH_SPI_FRAMER_MACROS_SVH

`ifndef ASSERT_OFF
`define SBSF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define SBSF_ASSERT_IMP(lbl, ante, cons, msg) \
	`SBSF_ASSERT(lbl, (ante) |-> (cons), msg)
`else
`define SBSF_ASSERT(lbl, prop, msg)
`define SBSF_ASSERT_IMP(lbl, ante, cons, msg)
`endif

`endif

// ===== design/sbsf_pkg.sv =====
// ----------------------------------------------------------------------------
// sbsf_pkg
// Types and constants shared by the sample batch framer modules.
// ----------------------------------------------------------------------------
package sbsf_pkg;

	typedef enum logic [2:0] {
		CMD_SAMPLE    = 3'd0,
		CMD_FILTER    = 3'd1,
		CMD_SYNC_RISE = 3'd2,
		CMD_SYNC_FALL = 3'd3,
		CMD_READ      = 3'd4
	} cmd_t;

	localparam logic REG_GAIN = 1'b0;
	localparam logic REG_MODE = 1'b1;

	localparam int SAMPLE_W = 24;
	localparam int GAIN_W   = 4;
	localparam int ENTRY_W  = 2 * SAMPLE_W + GAIN_W;
	localparam int IDX_W    = 5;
	localparam int ADDR_W   = IDX_W + 1;
	localparam int FILL_W   = 6;
	localparam int PTR_W    = 9;
	localparam int K_W      = 4;

	localparam int HEADER_LEN       = 6;
	localparam int BYTES_PER_SAMPLE = 10;

	localparam logic [7:0]        HEADER_BYTE = 8'hAB;
	localparam logic [7:0]        PAD_BYTE    = 8'h00;
	localparam logic [GAIN_W-1:0] GAIN_MAX    = 4'd8;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [ENTRY_W-1:0] data;
	} store_wr_t;

	typedef struct packed {
		logic [7:0] read_byte;
		logic       byte_valid;
		logic       frame_last;
		logic       frame_ready;
	} result_t;

endpackage

// ===== design/sample_batch_spi_framer.sv =====
// ----------------------------------------------------------------------------
// sample_batch_spi_framer
// Gathers converter samples into batches and serves them as a byte frame.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake            payload
//  s_*       in         s_tvalid / s_tready  tuser: cmd; tdata: adc_sample, filter_value
//  m_*       out        m_tvalid / m_tready  tdata: read_byte, byte_valid, frame_ready;
//                                            tlast: frame_last
//  cfg_*     in         cfg_we (no wait)     cfg_index selects gain_code / output_mode
//
//  An accepted transaction is registered in the input stage; its state update and
//  result then pass into the result register, from which the master side takes it.
//  One transaction is taken per cycle while the result register is free or being taken;
//  the next frame byte's store read is issued from the updated state, in time for it.
//  With the result register full and m_tready low, a held input transaction stalls
//  and s_tready drops. Reset clears all control state; the store holds no reset.
// ----------------------------------------------------------------------------
`include "sample_batch_spi_framer_macros.svh"

module sample_batch_spi_framer
	import sbsf_pkg::*;
#(
	parameter int BATCH_SIZE = 30
) (
	input  logic              clk,
	input  logic              arst_n,
	// slave side
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [47:0]       s_tdata,   // [23:0] adc_sample, [47:24] filter_value
	input  logic [2:0]        s_tuser,   // [2:0] cmd
	// master side
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [15:0]       m_tdata,   // [7:0] read_byte, [8] byte_valid,
	                                     // [9] frame_ready, [15:10] zero
	output logic              m_tlast,   // frame_last
	// configuration
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [GAIN_W-1:0] cfg_data
);

	// configuration registers
	logic [GAIN_W-1:0] gain_q;
	logic              mode_q;

	// input stage
	logic                valid_s1;
	logic [2:0]          cmd_s1;
	logic [SAMPLE_W-1:0] sample_s1;
	logic [SAMPLE_W-1:0] filter_s1;

	// result stage
	logic    valid_s2;
	result_t result_s2;

	logic               advance;
	result_t            result;
	store_wr_t          wr;
	logic [ADDR_W-1:0]  raddr;
	logic [ENTRY_W-1:0] rd_data;

	// advance the input stage when the result register is free or being taken
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= '0;
			mode_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GAIN: begin
					// drop gain codes above the legal range
					if (cfg_data <= GAIN_MAX) begin
						gain_q <= cfg_data;
					end
				end
				REG_MODE: mode_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1    <= s_tuser;
			sample_s1 <= s_tdata[SAMPLE_W-1:0];
			filter_s1 <= s_tdata[2*SAMPLE_W-1:SAMPLE_W];
		end
	end

	sbsf_core #(
		.BATCH_SIZE (BATCH_SIZE)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.cmd          (cmd_s1),
		.adc_sample   (sample_s1),
		.filter_value (filter_s1),
		.gain_code    (gain_q),
		.output_mode  (mode_q),
		.rd_data      (rd_data),
		.wr           (wr),
		.raddr        (raddr),
		.result       (result)
	);

	sbsf_store u_store (
		.clk   (clk),
		.wr    (wr),
		.raddr (raddr),
		.rdata (rd_data)
	);

	// hold the result until the master side takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {6'd0, result_s2.frame_ready, result_s2.byte_valid,
		result_s2.read_byte};
	assign m_tlast  = result_s2.frame_last;

	`SBSF_ASSERT_IMP(a_last_valid, m_tvalid && m_tlast, m_tdata[8],
		"frame end flagged on a byte that is not valid")
	`SBSF_ASSERT_IMP(a_last_drops_ready, m_tvalid && m_tlast, !m_tdata[9],
		"ready line still high after the frame end")
	`SBSF_ASSERT_IMP(a_stall_holds, valid_s1 && !advance, ##1 valid_s1,
		"stalled input stage lost its transaction")

endmodule

// ===== design/sbsf_store.sv =====
// ----------------------------------------------------------------------------
// sbsf_store
// Two-bank sample store, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module sbsf_store
	import sbsf_pkg::*;
(
	input  logic               clk,
	input  store_wr_t          wr,
	input  logic [ADDR_W-1:0]  raddr,
	output logic [ENTRY_W-1:0] rdata
);

	logic [ENTRY_W-1:0] mem [2**ADDR_W];
	logic [ENTRY_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.addr] <= wr.data;
		end
		// forward a write to the address being read
		if (wr.we && (wr.addr == raddr)) begin
			rdata_q <= wr.data;
		end else begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== design/sbsf_core.sv =====
// ----------------------------------------------------------------------------
// sbsf_core
// Batch and frame state with the per-transaction update logic.
// ----------------------------------------------------------------------------
`include "sample_batch_spi_framer_macros.svh"

module sbsf_core
	import sbsf_pkg::*;
#(
	parameter int BATCH_SIZE = 30
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  logic [2:0]          cmd,
	input  logic [SAMPLE_W-1:0] adc_sample,
	input  logic [SAMPLE_W-1:0] filter_value,
	input  logic [GAIN_W-1:0]   gain_code,
	input  logic                output_mode,
	input  logic [ENTRY_W-1:0]  rd_data,
	output store_wr_t           wr,
	output logic [ADDR_W-1:0]   raddr,
	output result_t             result
);

	localparam logic [FILL_W-1:0] BATCH_FILL = FILL_W'(BATCH_SIZE);
	localparam logic [15:0]       BATCH_CNT  = 16'(BATCH_SIZE);
	localparam logic [PTR_W-1:0]  FRAME_LEN  =
		PTR_W'(HEADER_LEN + BYTES_PER_SAMPLE * BATCH_SIZE);
	localparam logic [PTR_W-1:0]  HDR_LEN    = PTR_W'(HEADER_LEN);
	localparam logic [K_W-1:0]    K_LAST     = K_W'(BYTES_PER_SAMPLE - 1);

	logic [FILL_W-1:0]   fill_q,  fill_n;
	logic                full_q,  full_n;
	logic [15:0]         seq_q,   seq_n;
	logic [SAMPLE_W-1:0] held_q,  held_n;
	logic                bank_q,  bank_n;
	logic                ready_q, ready_n;
	logic [PTR_W-1:0]    ptr_q,   ptr_n;
	logic [K_W-1:0]      k_q,     k_n;
	logic [IDX_W-1:0]    idx_q,   idx_n;
	logic [15:0]         fseq_q,  fseq_n;
	logic                fmode_q, fmode_n;

	logic [7:0]          frame_byte;
	logic [SAMPLE_W-1:0] e_raw, e_flt;
	logic [GAIN_W-1:0]   e_gain;

	assign e_raw  = rd_data[SAMPLE_W-1:0];
	assign e_flt  = rd_data[2*SAMPLE_W-1:SAMPLE_W];
	assign e_gain = rd_data[ENTRY_W-1:2*SAMPLE_W];

	always_comb begin
		frame_byte = PAD_BYTE;
		if (ptr_q < HDR_LEN) begin
			case (ptr_q[2:0])
				3'd0:    frame_byte = HEADER_BYTE;
				3'd1:    frame_byte = BATCH_CNT[7:0];
				3'd2:    frame_byte = BATCH_CNT[15:8];
				3'd3:    frame_byte = fseq_q[7:0];
				3'd4:    frame_byte = fseq_q[15:8];
				3'd5:    frame_byte = {7'd0, fmode_q};
				default: frame_byte = PAD_BYTE;
			endcase
		end else begin
			case (k_q)
				4'd0, 4'd2: frame_byte = e_raw[7:0];
				4'd1, 4'd3: frame_byte = e_raw[15:8];
				4'd4:       frame_byte = e_raw[23:16];
				4'd5:       frame_byte = e_flt[7:0];
				4'd6:       frame_byte = e_flt[15:8];
				4'd7:       frame_byte = e_flt[23:16];
				4'd8:       frame_byte = {{(8-GAIN_W){1'b0}}, e_gain};
				default:    frame_byte = PAD_BYTE;
			endcase
		end
	end

	always_comb begin
		fill_n  = fill_q;
		full_n  = full_q;
		seq_n   = seq_q;
		held_n  = held_q;
		bank_n  = bank_q;
		ready_n = ready_q;
		ptr_n   = ptr_q;
		k_n     = k_q;
		idx_n   = idx_q;
		fseq_n  = fseq_q;
		fmode_n = fmode_q;
		wr      = '{we: 1'b0, addr: {bank_q, fill_q[IDX_W-1:0]},
			data: {gain_code, held_q, adc_sample}};
		result  = '{read_byte: 8'd0, byte_valid: 1'b0, frame_last: 1'b0,
			frame_ready: 1'b0};

		case (cmd_t'(cmd))
			CMD_SAMPLE: begin
				if ((fill_q < BATCH_FILL) && !full_q) begin
					wr.we  = advance;
					fill_n = fill_q + 1'b1;
					if (fill_n >= BATCH_FILL) begin
						full_n = 1'b1;
					end
				end
			end
			CMD_FILTER: begin
				held_n = filter_value;
			end
			CMD_SYNC_RISE: begin
				fill_n = '0;
				full_n = 1'b0;
			end
			CMD_SYNC_FALL: begin
				fill_n  = '0;
				full_n  = 1'b0;
				ready_n = 1'b0;
			end
			CMD_READ: begin
				if (ready_q && (ptr_q < FRAME_LEN)) begin
					result.read_byte  = frame_byte;
					result.byte_valid = 1'b1;
					ptr_n = ptr_q + 1'b1;
					if (ptr_q >= HDR_LEN) begin
						if (k_q == K_LAST) begin
							k_n   = '0;
							idx_n = idx_q + 1'b1;
						end else begin
							k_n = k_q + 1'b1;
						end
					end
					if (ptr_n >= FRAME_LEN) begin
						result.frame_last = 1'b1;
						ready_n = 1'b0;
						full_n  = 1'b0;
						fill_n  = '0;
					end
				end
			end
			default: begin
			end
		endcase

		// present a full batch once no frame is out
		if (full_n && !ready_n) begin
			bank_n  = ~bank_q;
			fseq_n  = seq_q;
			fmode_n = output_mode;
			seq_n   = seq_q + 1'b1;
			ptr_n   = '0;
			k_n     = '0;
			idx_n   = '0;
			ready_n = 1'b1;
		end

		result.frame_ready = ready_n;
		// fetch the entry for the byte after this transaction
		raddr = advance ? {~bank_n, idx_n} : {~bank_q, idx_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			full_q  <= 1'b0;
			seq_q   <= '0;
			held_q  <= '0;
			bank_q  <= 1'b0;
			ready_q <= 1'b0;
			ptr_q   <= '0;
			k_q     <= '0;
			idx_q   <= '0;
			fseq_q  <= '0;
			fmode_q <= 1'b0;
		end else if (advance) begin
			fill_q  <= fill_n;
			full_q  <= full_n;
			seq_q   <= seq_n;
			held_q  <= held_n;
			bank_q  <= bank_n;
			ready_q <= ready_n;
			ptr_q   <= ptr_n;
			k_q     <= k_n;
			idx_q   <= idx_n;
			fseq_q  <= fseq_n;
			fmode_q <= fmode_n;
		end
	end

	`SBSF_ASSERT(a_fill_bound, fill_q <= BATCH_FILL, "fill count beyond batch size")
	`SBSF_ASSERT_IMP(a_ptr_bound, ready_q, ptr_q < FRAME_LEN, "presented frame past its end")
	`SBSF_ASSERT(a_k_bound, k_q <= K_LAST, "byte-in-sample counter out of range")

endmodule
